// ===== sv/apyd_pkg.sv =====
// ----------------------------------------------------------------------------
// apyd_pkg
// Shared types, constants and saturation helpers for the attitude PID and
// yaw damper block.
// ----------------------------------------------------------------------------
package apyd_pkg;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned ERR_W   = 17;
  localparam int unsigned INTEG_W = 32;
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W   = 50;
  localparam int unsigned IDX_W   = 3;

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_ROLL_KP   = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROLL_KI   = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROLL_KD   = 3'd2;
  localparam logic [IDX_W-1:0] REG_PITCH_KP  = 3'd3;
  localparam logic [IDX_W-1:0] REG_PITCH_KI  = 3'd4;
  localparam logic [IDX_W-1:0] REG_PITCH_KD  = 3'd5;
  localparam logic [IDX_W-1:0] REG_STEP_TIME = 3'd6;

  // Register reset values
  localparam logic [DATA_W-1:0] KP_RST   = 16'd4096;
  localparam logic [DATA_W-1:0] KI_RST   = 16'd0;
  localparam logic [DATA_W-1:0] KD_RST   = 16'd0;
  localparam logic [DATA_W-1:0] STEP_RST = 16'd1311;

  // Yaw high-pass coefficients, Q0.16
  localparam logic signed [MUL_B_W-1:0] YAW_B = 18'sd4260;
  localparam logic signed [MUL_B_W-1:0] YAW_A = 18'sd62967;

  // Round-half-up offsets preloaded into the accumulator
  localparam logic signed [ACC_W-1:0] ROUND_PID = ACC_W'(64'sd524288);
  localparam logic signed [ACC_W-1:0] ROUND_YAW = ACC_W'(64'sd32768);

  typedef enum logic [3:0] {
    OP_RINC,
    OP_PINC,
    OP_RKP,
    OP_RKI,
    OP_RKD,
    OP_PKP,
    OP_PKI,
    OP_PKD,
    OP_YB,
    OP_YA
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic valid;
    op_e  op;
  } issue_t;

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [33:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[33:15] == {19{v[33]}}) begin
      r = v[15:0];
    end else if (v[33]) begin
      r = 16'sh8000;
    end else begin
      r = 16'sh7fff;
    end
    return r;
  endfunction

  function automatic logic signed [INTEG_W-1:0] sat32(input logic signed [INTEG_W:0] v);
    logic signed [INTEG_W-1:0] r;
    if (v[INTEG_W] == v[INTEG_W-1]) begin
      r = v[INTEG_W-1:0];
    end else if (v[INTEG_W]) begin
      r = {1'b1, {(INTEG_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(INTEG_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== sv/apyd_seq.sv =====
// ----------------------------------------------------------------------------
// apyd_seq
// Sequencer: takes one item, then issues the ten multiply steps in order,
// holding the last one while the previous result is still unread.
// ----------------------------------------------------------------------------
module apyd_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_busy_i,
  output apyd_pkg::issue_t  issue_o
);

  apyd_pkg::state_e state_q, state_d;
  apyd_pkg::op_e    op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= apyd_pkg::ST_IDLE;
      op_q    <= apyd_pkg::OP_RINC;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    in_ready_o    = 1'b0;
    issue_o.valid = 1'b0;
    issue_o.op    = op_q;
    unique case (state_q)
      apyd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = apyd_pkg::ST_RUN;
          op_d    = apyd_pkg::OP_RINC;
        end
      end
      apyd_pkg::ST_RUN: begin
        // final step writes the output register, so wait for it to drain
        issue_o.valid = !(op_q == apyd_pkg::OP_YA && out_busy_i);
        if (issue_o.valid) begin
          if (op_q == apyd_pkg::OP_YA) begin
            state_d = apyd_pkg::ST_IDLE;
          end else begin
            op_d = apyd_pkg::op_e'(op_q + 4'd1);
          end
        end
      end
      default: begin
        state_d = apyd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/apyd_mul.sv =====
// ----------------------------------------------------------------------------
// apyd_mul
// Shared signed multiplier with a registered product and step tag.
// ----------------------------------------------------------------------------
module apyd_mul (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  apyd_pkg::issue_t                          issue_i,
  input  logic signed [apyd_pkg::MUL_A_W-1:0]       a_i,
  input  logic signed [apyd_pkg::MUL_B_W-1:0]       b_i,
  output apyd_pkg::issue_t                          res_o,
  output logic signed [apyd_pkg::PROD_W-1:0]        prod_o
);

  apyd_pkg::issue_t                         res_q;
  logic signed [apyd_pkg::PROD_W-1:0]       prod_q;
  logic signed [apyd_pkg::PROD_W-1:0]       prod_d;

  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q.valid <= 1'b0;
      res_q.op    <= apyd_pkg::OP_RINC;
    end else begin
      res_q <= issue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i.valid) begin
      prod_q <= prod_d;
    end
  end

  assign res_o  = res_q;
  assign prod_o = prod_q;

endmodule

// ===== sv/attitude_pid_yaw_damper.sv =====
// ----------------------------------------------------------------------------
// attitude_pid_yaw_damper
// Roll and pitch PID angle loops with integrators, plus a first-order
// high-pass yaw damper, on one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one tick: angle commands,
//   measured angles and body rates, all signed Q4.12. Output channel
//   (out_valid_o / out_ready_i) returns the roll, pitch and yaw rate commands.
//   The user must write gains and step time on cfg_we_i / cfg_idx_i / cfg_data_i
//   only while the block is idle; the block does not enforce this. An index
//   beyond six is ignored. Each item runs ten multiply steps through one 33x18
//   multiplier, one step a cycle unless the last step waits on a stalled
//   output, with a registered product ahead of the accumulator. A new item
//   is accepted only after the last step of the current one has issued;
//   in_ready_o is high only between items.
//   If the receiver stalls, the finished item is held in the output register;
//   the next item proceeds up to its last step and waits there until the
//   held item is taken.
//   Reset restores the default gains and step time and clears the
//   integrators and the yaw filter history. No clearing pass is needed.
// ----------------------------------------------------------------------------
module attitude_pid_yaw_damper (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [apyd_pkg::IDX_W-1:0]             cfg_idx_i,
  input  logic [apyd_pkg::DATA_W-1:0]            cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [apyd_pkg::DATA_W-1:0]     roll_cmd_i,
  input  logic signed [apyd_pkg::DATA_W-1:0]     pitch_cmd_i,
  input  logic signed [apyd_pkg::DATA_W-1:0]     roll_angle_i,
  input  logic signed [apyd_pkg::DATA_W-1:0]     pitch_angle_i,
  input  logic signed [apyd_pkg::DATA_W-1:0]     roll_rate_i,
  input  logic signed [apyd_pkg::DATA_W-1:0]     pitch_rate_i,
  input  logic signed [apyd_pkg::DATA_W-1:0]     yaw_rate_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [apyd_pkg::DATA_W-1:0]     roll_rate_cmd_o,
  output logic signed [apyd_pkg::DATA_W-1:0]     pitch_rate_cmd_o,
  output logic signed [apyd_pkg::DATA_W-1:0]     yaw_rate_cmd_o
);

  localparam int unsigned DW = apyd_pkg::DATA_W;
  localparam int unsigned EW = apyd_pkg::ERR_W;
  localparam int unsigned IW = apyd_pkg::INTEG_W;
  localparam int unsigned AW = apyd_pkg::MUL_A_W;
  localparam int unsigned BW = apyd_pkg::MUL_B_W;
  localparam int unsigned PW = apyd_pkg::PROD_W;
  localparam int unsigned CW = apyd_pkg::ACC_W;

  // configuration
  logic signed [DW-1:0] roll_kp_q, roll_ki_q, roll_kd_q;
  logic signed [DW-1:0] pitch_kp_q, pitch_ki_q, pitch_kd_q;
  logic        [DW-1:0] step_time_q;

  // filter and integrator state
  logic signed [IW-1:0] roll_integ_q, roll_integ_d;
  logic signed [IW-1:0] pitch_integ_q, pitch_integ_d;
  logic signed [DW-1:0] yaw_rate_prev_q, yaw_rate_prev_d;
  logic signed [DW-1:0] yaw_out_prev_q, yaw_out_prev_d;

  // captured item
  logic signed [EW-1:0] roll_err_q, pitch_err_q;
  logic signed [DW-1:0] roll_rate_q, pitch_rate_q, yaw_rate_q;

  // datapath
  logic signed [CW-1:0] acc_q, acc_d;
  logic signed [DW-1:0] roll_res_q, roll_res_d;
  logic signed [DW-1:0] pitch_res_q, pitch_res_d;
  logic signed [DW-1:0] roll_out_q, pitch_out_q, yaw_out_q;
  logic signed [DW-1:0] yaw_sat;
  logic                 out_valid_q, out_valid_d;
  logic                 out_load;

  logic                 in_accept;
  apyd_pkg::issue_t     issue;
  apyd_pkg::issue_t     res;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [EW-1:0] yaw_diff;
  logic signed [CW-1:0] prod_acc;
  logic signed [CW-1:0] prod_sh8;
  logic signed [IW:0]   integ_src;
  logic signed [IW:0]   integ_sum;

  assign in_accept = in_valid_i && in_ready_o;

  apyd_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_busy_i (out_valid_q && !out_ready_i),
    .issue_o    (issue)
  );

  // operand select
  assign yaw_diff = EW'(yaw_rate_q) - EW'(yaw_rate_prev_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (issue.op)
      apyd_pkg::OP_RINC: begin
        mul_a = AW'(roll_err_q);
        mul_b = BW'({2'b00, step_time_q});
      end
      apyd_pkg::OP_PINC: begin
        mul_a = AW'(pitch_err_q);
        mul_b = BW'({2'b00, step_time_q});
      end
      apyd_pkg::OP_RKP: begin
        mul_a = AW'(roll_err_q);
        mul_b = BW'(roll_kp_q);
      end
      apyd_pkg::OP_RKI: begin
        mul_a = AW'(roll_integ_q);
        mul_b = BW'(roll_ki_q);
      end
      apyd_pkg::OP_RKD: begin
        mul_a = AW'(roll_rate_q);
        mul_b = BW'(roll_kd_q);
      end
      apyd_pkg::OP_PKP: begin
        mul_a = AW'(pitch_err_q);
        mul_b = BW'(pitch_kp_q);
      end
      apyd_pkg::OP_PKI: begin
        mul_a = AW'(pitch_integ_q);
        mul_b = BW'(pitch_ki_q);
      end
      apyd_pkg::OP_PKD: begin
        mul_a = AW'(pitch_rate_q);
        mul_b = BW'(pitch_kd_q);
      end
      apyd_pkg::OP_YB: begin
        mul_a = AW'(yaw_diff);
        mul_b = apyd_pkg::YAW_B;
      end
      apyd_pkg::OP_YA: begin
        mul_a = AW'(yaw_out_prev_q);
        mul_b = apyd_pkg::YAW_A;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  apyd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .res_o   (res),
    .prod_o  (prod)
  );

  // accumulate / commit stage
  assign prod_acc = prod[CW-1:0];
  assign prod_sh8 = {prod[CW-9:0], 8'b0};

  // integrator step: floor((p + 128) / 256) is p >>> 8 plus bit 7 as carry in
  assign integ_src = (res.op == apyd_pkg::OP_PINC) ? (IW+1)'(pitch_integ_q)
                                                   : (IW+1)'(roll_integ_q);
  assign integ_sum = integ_src + prod[IW+8:8] + (IW+1)'(prod[7]);

  always_comb begin
    acc_d           = acc_q;
    roll_integ_d    = roll_integ_q;
    pitch_integ_d   = pitch_integ_q;
    roll_res_d      = roll_res_q;
    pitch_res_d     = pitch_res_q;
    yaw_rate_prev_d = yaw_rate_prev_q;
    yaw_out_prev_d  = yaw_out_prev_q;
    out_load        = 1'b0;
    yaw_sat         = apyd_pkg::sat16(acc_d[CW-1:16]);
    if (res.valid) begin
      unique case (res.op)
        apyd_pkg::OP_RINC: roll_integ_d  = apyd_pkg::sat32(integ_sum);
        apyd_pkg::OP_PINC: pitch_integ_d = apyd_pkg::sat32(integ_sum);
        apyd_pkg::OP_RKP, apyd_pkg::OP_PKP: begin
          acc_d = apyd_pkg::ROUND_PID + prod_sh8;
        end
        apyd_pkg::OP_RKI, apyd_pkg::OP_PKI: begin
          acc_d = acc_q + prod_acc;
        end
        apyd_pkg::OP_RKD: begin
          acc_d      = acc_q - prod_sh8;
          roll_res_d = apyd_pkg::sat16(34'($signed(acc_d[CW-1:20])));
        end
        apyd_pkg::OP_PKD: begin
          acc_d       = acc_q - prod_sh8;
          pitch_res_d = apyd_pkg::sat16(34'($signed(acc_d[CW-1:20])));
        end
        apyd_pkg::OP_YB: begin
          acc_d = apyd_pkg::ROUND_YAW + prod_acc;
        end
        apyd_pkg::OP_YA: begin
          acc_d           = acc_q + prod_acc;
          out_load        = 1'b1;
          yaw_rate_prev_d = yaw_rate_q;
        end
        default: begin
          acc_d = acc_q;
        end
      endcase
    end
    yaw_sat = apyd_pkg::sat16(acc_d[CW-1:16]);
    if (out_load) begin
      yaw_out_prev_d = yaw_sat;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_kp_q       <= apyd_pkg::KP_RST;
      roll_ki_q       <= apyd_pkg::KI_RST;
      roll_kd_q       <= apyd_pkg::KD_RST;
      pitch_kp_q      <= apyd_pkg::KP_RST;
      pitch_ki_q      <= apyd_pkg::KI_RST;
      pitch_kd_q      <= apyd_pkg::KD_RST;
      step_time_q     <= apyd_pkg::STEP_RST;
      roll_integ_q    <= '0;
      pitch_integ_q   <= '0;
      yaw_rate_prev_q <= '0;
      yaw_out_prev_q  <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          apyd_pkg::REG_ROLL_KP:   roll_kp_q   <= cfg_data_i;
          apyd_pkg::REG_ROLL_KI:   roll_ki_q   <= cfg_data_i;
          apyd_pkg::REG_ROLL_KD:   roll_kd_q   <= cfg_data_i;
          apyd_pkg::REG_PITCH_KP:  pitch_kp_q  <= cfg_data_i;
          apyd_pkg::REG_PITCH_KI:  pitch_ki_q  <= cfg_data_i;
          apyd_pkg::REG_PITCH_KD:  pitch_kd_q  <= cfg_data_i;
          apyd_pkg::REG_STEP_TIME: step_time_q <= cfg_data_i;
          default: ;
        endcase
      end
      roll_integ_q    <= roll_integ_d;
      pitch_integ_q   <= pitch_integ_d;
      yaw_rate_prev_q <= yaw_rate_prev_d;
      yaw_out_prev_q  <= yaw_out_prev_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      roll_err_q   <= EW'(roll_cmd_i) - EW'(roll_angle_i);
      pitch_err_q  <= EW'(pitch_cmd_i) - EW'(pitch_angle_i);
      roll_rate_q  <= roll_rate_i;
      pitch_rate_q <= pitch_rate_i;
      yaw_rate_q   <= yaw_rate_i;
    end
    acc_q       <= acc_d;
    roll_res_q  <= roll_res_d;
    pitch_res_q <= pitch_res_d;
    if (out_load) begin
      roll_out_q  <= roll_res_q;
      pitch_out_q <= pitch_res_q;
      yaw_out_q   <= yaw_sat;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign roll_rate_cmd_o  = roll_out_q;
  assign pitch_rate_cmd_o = pitch_out_q;
  assign yaw_rate_cmd_o   = yaw_out_q;

endmodule
